// ----- src/sdi_pkg.sv -----
// ----------------------------------------------------------------------------
// sdi_pkg: shared types and constants
// Phase and stage codes, request kinds, status codes, register indices, channel payload types.
// ----------------------------------------------------------------------------
package sdi_pkg;

   typedef enum logic [3:0] {
      PH_OFF, PH_DESEL, PH_DELAY, PH_IDLECLK, PH_SEL, PH_WAIT,
      PH_FRAME, PH_POLL, PH_EXTRA, PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_POWER, ST_CMD0, ST_CMD8, ST_CMD55, ST_ACMD41, ST_CMD58
   } stage_type;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_BYTE  = 2'd1;
   localparam logic [1:0] KIND_TICK  = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_BUSY     = 2'd1;
   localparam logic [1:0] STAT_TIMEOUT  = 2'd2;
   localparam logic [1:0] STAT_MISMATCH = 2'd3;

   localparam logic [2:0] CSR_READY_LIMIT = 3'd0;
   localparam logic [2:0] CSR_INIT_LIMIT  = 3'd1;
   localparam logic [2:0] CSR_POWERUP     = 3'd2;
   localparam logic [2:0] CSR_IF_COND     = 3'd3;
   localparam logic [2:0] CSR_OP_COND     = 3'd4;

   localparam int IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       cs_high;
      logic       done_res;
      logic [1:0] status;
      logic       block_addr;
      logic       capacity_known;
   } rsp_type;

endpackage

// ----- src/sdi_if.sv -----
// ----------------------------------------------------------------------------
// sdi_req_if / sdi_rsp_if: valid-ready channels
// Request and result channels with source and sink modports.
// ----------------------------------------------------------------------------
interface sdi_req_if;
   logic valid;
   logic ready;
   sdi_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface sdi_rsp_if;
   logic valid;
   logic ready;
   sdi_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ----- src/sd_spi_init_sequencer.sv -----
// ----------------------------------------------------------------------------
// sd_spi_init_sequencer: SD card SPI-mode start-up sequencer
// Steps the card bring-up one byte exchange or microsecond tick at a time.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  req      in         kind, rx_byte
//  rsp      out        tx_valid, tx_byte, cs_high, done_res, status, capacity
//  csr      in         write enable, index, 32-bit data
//
// one request per cycle; the state update is done in the accept cycle and
// the result lands in a one-entry output register.
// a request is taken while the output register is empty or being drained.
// synchronous active-high reset returns to idle with default registers.
module sd_spi_init_sequencer (
   input  logic clock,
   input  logic reset,
   sdi_req_if.sink   req,
   sdi_rsp_if.source rsp,
   input  logic                             csr_we,
   input  logic [sdi_pkg::IDX_W-1:0]        csr_index,
   input  logic [sdi_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [15:0] rdy_lim_ff, ini_lim_ff;
   logic [19:0] pwr_ff;
   logic [31:0] ifc_ff, opc_ff;

   sdi_pkg::phase_type phase_ff, phase_in;
   sdi_pkg::stage_type stage_ff, stage_in;
   logic [2:0]  bidx_ff, bidx_in;
   logic [8:0]  poll_ff, poll_in;
   logic [15:0] retry_ff, retry_in, idle_ff, idle_in;
   logic [19:0] dly_ff, dly_in;
   logic [7:0]  last_ff, last_in;
   logic [1:0]  cap_ff, cap_in, fail_ff, fail_in;
   logic        cs_ff, cs_in;

   logic    rv_ff;
   sdi_pkg::rsp_type rd_ff;
   logic    emit;
   sdi_pkg::rsp_type od;
   logic    acc;

   assign req.ready = !rv_ff || rsp.ready;
   assign acc = req.valid && req.ready;
   assign rsp.valid = rv_ff;
   assign rsp.data = rd_ff;

   function automatic logic [7:0] fbyte(sdi_pkg::stage_type s, logic [2:0] i,
                                        logic [31:0] ifc, logic [31:0] opc);
      logic [5:0] cmd;
      logic [31:0] arg;
      logic [7:0] crc;
      cmd = 6'd58; arg = 32'd0; crc = 8'hFF;
      unique case (s)
         sdi_pkg::ST_CMD0: begin cmd = 6'd0; crc = 8'h95; end
         sdi_pkg::ST_CMD8: begin cmd = 6'd8; arg = ifc; crc = 8'h87; end
         sdi_pkg::ST_CMD55: cmd = 6'd55;
         sdi_pkg::ST_ACMD41: begin cmd = 6'd41; arg = opc; end
         default: cmd = 6'd58;
      endcase
      case (i)
         3'd0: fbyte = {2'b01, cmd};
         3'd1: fbyte = arg[31:24];
         3'd2: fbyte = arg[23:16];
         3'd3: fbyte = arg[15:8];
         3'd4: fbyte = arg[7:0];
         default: fbyte = crc;
      endcase
   endfunction

   always_comb begin
      logic [7:0] rx;
      logic [15:0] rc;
      logic do_after, do_desel, do_sel, do_frame, do_fin, do_delay;
      logic [1:0] fst;
      logic [19:0] dn;
      logic [15:0] ic;
      logic [8:0] pc;
      logic [2:0] bi;
      logic [7:0] lr;
      rx = req.data.rx_byte;
      phase_in = phase_ff; stage_in = stage_ff; bidx_in = bidx_ff;
      poll_in = poll_ff; retry_in = retry_ff; idle_in = idle_ff;
      dly_in = dly_ff; last_in = last_ff; cap_in = cap_ff;
      fail_in = fail_ff; cs_in = cs_ff;
      emit = 1'b0; od = '0;
      do_after = 1'b0; do_desel = 1'b0; do_sel = 1'b0; do_frame = 1'b0;
      do_fin = 1'b0; do_delay = 1'b0; fst = sdi_pkg::STAT_OK; dn = 20'd0;
      rc = 16'd0; ic = 16'd0; pc = 9'd0; bi = 3'd0; lr = 8'd0;
      if (req.data.kind == sdi_pkg::KIND_START) begin
         cap_in = 2'd0; fail_in = 2'd0; retry_in = 16'd0; poll_in = 9'd0;
         idle_in = 16'd0; dly_in = 20'd0; last_in = 8'hFF;
         stage_in = sdi_pkg::ST_POWER; do_desel = 1'b1;
      end else if (req.data.kind == sdi_pkg::KIND_BYTE) begin
         unique case (phase_ff)
            sdi_pkg::PH_DESEL:
               if (bidx_ff == 3'd0) begin
                  bidx_in = 3'd1; emit = 1'b1; od.tx_byte = 8'hFF;
               end else begin
                  unique case (stage_ff)
                     sdi_pkg::ST_POWER: begin do_delay = 1'b1; dn = pwr_ff; end
                     sdi_pkg::ST_CMD0, sdi_pkg::ST_CMD8:
                        if (fail_ff != 2'd0) begin
                           do_fin = 1'b1; fst = fail_ff;
                        end else begin
                           stage_in = (stage_ff == sdi_pkg::ST_CMD0) ?
                              sdi_pkg::ST_CMD8 : sdi_pkg::ST_CMD55;
                           retry_in = 16'd0; do_sel = 1'b1;
                        end
                     sdi_pkg::ST_CMD55:
                        if (last_ff < 8'd2) begin
                           stage_in = sdi_pkg::ST_ACMD41; do_sel = 1'b1;
                        end else begin do_delay = 1'b1; dn = 20'd100; end
                     sdi_pkg::ST_ACMD41:
                        if (last_ff == 8'd0) begin
                           stage_in = sdi_pkg::ST_CMD58; retry_in = 16'd0;
                           do_sel = 1'b1;
                        end else begin do_delay = 1'b1; dn = 20'd100; end
                     default: begin do_fin = 1'b1; fst = fail_ff; end
                  endcase
               end
            sdi_pkg::PH_IDLECLK: begin
               pc = poll_ff + 9'd1; poll_in = pc;
               if (pc < 9'd10) begin emit = 1'b1; od.tx_byte = 8'hFF; end
               else begin
                  stage_in = sdi_pkg::ST_CMD0; retry_in = 16'd0; do_sel = 1'b1;
               end
            end
            sdi_pkg::PH_SEL: begin
               emit = 1'b1; od.tx_byte = 8'hFF;
               if (bidx_ff == 3'd0) bidx_in = 3'd1;
               else begin phase_in = sdi_pkg::PH_WAIT; idle_in = 16'd0; end
            end
            sdi_pkg::PH_WAIT:
               if (rx == 8'hFF) do_frame = 1'b1;
               else begin
                  ic = idle_ff + 16'd1; idle_in = ic;
                  if (ic >= rdy_lim_ff) begin
                     do_fin = 1'b1; fst = sdi_pkg::STAT_BUSY;
                  end else begin emit = 1'b1; od.tx_byte = 8'hFF; end
               end
            sdi_pkg::PH_FRAME: begin
               bi = bidx_ff + 3'd1; bidx_in = bi; emit = 1'b1;
               if (bi < 3'd6) od.tx_byte = fbyte(stage_ff, bi, ifc_ff, opc_ff);
               else begin
                  phase_in = sdi_pkg::PH_POLL; poll_in = 9'd0; od.tx_byte = 8'hFF;
               end
            end
            sdi_pkg::PH_POLL: begin
               pc = poll_ff + 9'd1; poll_in = pc;
               if (rx[7] && pc < 9'd256) begin emit = 1'b1; od.tx_byte = 8'hFF; end
               else begin
                  last_in = rx;
                  unique case (stage_ff)
                     sdi_pkg::ST_CMD0:
                        if (rx == 8'd1) do_desel = 1'b1;
                        else begin do_delay = 1'b1; dn = 20'd1; end
                     sdi_pkg::ST_CMD8, sdi_pkg::ST_CMD58:
                        if (rx == ((stage_ff == sdi_pkg::ST_CMD8) ? 8'd1 : 8'd0))
                        begin
                           phase_in = sdi_pkg::PH_EXTRA; bidx_in = 3'd0;
                           emit = 1'b1; od.tx_byte = 8'hFF;
                        end else begin do_delay = 1'b1; dn = 20'd1; end
                     default: do_desel = 1'b1;
                  endcase
               end
            end
            sdi_pkg::PH_EXTRA: begin
               lr = last_ff;
               if (bidx_ff == 3'd0 && stage_ff == sdi_pkg::ST_CMD58) lr = rx;
               last_in = lr;
               bi = bidx_ff + 3'd1; bidx_in = bi;
               if (bi < 3'd4) begin emit = 1'b1; od.tx_byte = 8'hFF; end
               else begin
                  if (stage_ff == sdi_pkg::ST_CMD8) begin
                     last_in = rx;
                     if (rx != ifc_ff[7:0]) fail_in = sdi_pkg::STAT_MISMATCH;
                  end else if (lr[7]) cap_in = {lr[6], 1'b1};
                  do_desel = 1'b1;
               end
            end
            default: ;
         endcase
      end else if (req.data.kind == sdi_pkg::KIND_TICK &&
                   phase_ff == sdi_pkg::PH_DELAY) begin
         dly_in = dly_ff - 20'd1;
         if (dly_in == 20'd0) do_after = 1'b1;
      end

      if (do_delay) begin
         dly_in = dn;
         if (dn == 20'd0) do_after = 1'b1;
         else phase_in = sdi_pkg::PH_DELAY;
      end
      if (do_after) begin
         rc = retry_ff + 16'd1;
         if (stage_ff == sdi_pkg::ST_POWER) begin
            phase_in = sdi_pkg::PH_IDLECLK; poll_in = 9'd0;
            emit = 1'b1; od.tx_byte = 8'hFF;
         end else if (stage_ff == sdi_pkg::ST_CMD55 ||
                      stage_ff == sdi_pkg::ST_ACMD41) begin
            retry_in = rc;
            if (rc >= ini_lim_ff) begin do_fin = 1'b1; fst = sdi_pkg::STAT_TIMEOUT; end
            else begin stage_in = sdi_pkg::ST_CMD55; do_sel = 1'b1; end
         end else begin
            retry_in = rc;
            if (rc >= rdy_lim_ff) begin
               fail_in = sdi_pkg::STAT_TIMEOUT; do_desel = 1'b1;
            end else do_frame = 1'b1;
         end
      end
      if (do_desel) begin
         phase_in = sdi_pkg::PH_DESEL; bidx_in = 3'd0; emit = 1'b1;
         od.tx_byte = 8'hFF; od.cs_high = cs_ff; cs_in = 1'b1;
      end else if (do_sel) begin
         phase_in = sdi_pkg::PH_SEL; bidx_in = 3'd0; emit = 1'b1;
         od.tx_byte = 8'hFF; od.cs_high = cs_ff; cs_in = 1'b0;
      end else if (do_frame) begin
         phase_in = sdi_pkg::PH_FRAME; bidx_in = 3'd0; emit = 1'b1;
         od.tx_byte = fbyte(stage_in, 3'd0, ifc_ff, opc_ff);
         od.cs_high = cs_ff;
      end else if (do_fin) begin
         phase_in = sdi_pkg::PH_DONE; emit = 1'b1; od.cs_high = cs_ff;
         od.done_res = 1'b1; od.status = fst;
      end else begin
         od.cs_high = cs_ff;
      end
      if (emit && !od.done_res) od.tx_valid = 1'b1;
      if (od.done_res) begin
         od.tx_byte = 8'd0;
         od.block_addr = cap_in[1]; od.capacity_known = cap_in[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdy_lim_ff <= 16'd1000; ini_lim_ff <= 16'd1000; pwr_ff <= 20'd50000;
         ifc_ff <= 32'h1AA; opc_ff <= 32'h4000_0000;
      end else if (csr_we) begin
         unique case (csr_index)
            sdi_pkg::CSR_READY_LIMIT: rdy_lim_ff <= csr_wdata[15:0];
            sdi_pkg::CSR_INIT_LIMIT: ini_lim_ff <= csr_wdata[15:0];
            sdi_pkg::CSR_POWERUP: pwr_ff <= csr_wdata[19:0];
            sdi_pkg::CSR_IF_COND: ifc_ff <= csr_wdata;
            sdi_pkg::CSR_OP_COND: opc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdi_pkg::PH_OFF; stage_ff <= sdi_pkg::ST_POWER;
         bidx_ff <= 3'd0; poll_ff <= 9'd0; retry_ff <= 16'd0; idle_ff <= 16'd0;
         dly_ff <= 20'd0; last_ff <= 8'hFF; cap_ff <= 2'd0; fail_ff <= 2'd0;
         cs_ff <= 1'b1; rv_ff <= 1'b0;
      end else begin
         if (acc) begin
            phase_ff <= phase_in; stage_ff <= stage_in; bidx_ff <= bidx_in;
            poll_ff <= poll_in; retry_ff <= retry_in; idle_ff <= idle_in;
            dly_ff <= dly_in; last_ff <= last_in; cap_ff <= cap_in;
            fail_ff <= fail_in; cs_ff <= cs_in;
         end
         if (acc) rv_ff <= emit;
         else if (rsp.ready) rv_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && emit) rd_ff <= od;
   end

`ifndef NO_ASSERTIONS
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rv_ff && !rsp.ready |=> rv_ff && $stable(rd_ff))
      else $error("result lost under stall");
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> !(rd_ff.tx_valid && rd_ff.done_res))
      else $error("result both byte and done");
   a_done: assert property (@(posedge clock) disable iff (reset)
      acc && emit && od.done_res |=> phase_ff == sdi_pkg::PH_DONE)
      else $error("done without done phase");
`endif

endmodule

// ----- tb/tb_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checker: bring-up sequencer scoreboard
// Follows every accepted request and register write with its own model of
// the card start-up sequence, queues the predicted byte or done result and
// compares it with each result the block hands out.
// ----------------------------------------------------------------------------
module tb_checker (
   input  logic                           clock,
   input  logic                           reset,
   sdi_req_if                             req,
   sdi_rsp_if                             rsp,
   input  logic                           csr_we,
   input  logic [sdi_pkg::IDX_W-1:0]      csr_index,
   input  logic [sdi_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             errors,
   output int                             pending,
   output int                             results_seen,
   output sdi_pkg::phase_type             hint_phase,
   output sdi_pkg::stage_type             hint_stage
);

   logic [15:0] ready_limit, init_limit;
   logic [19:0] powerup_us;
   logic [31:0] if_arg, op_arg;

   sdi_pkg::phase_type ph;
   sdi_pkg::stage_type stg;
   logic [2:0]  byte_idx;
   logic [8:0]  poll_cnt;
   logic [15:0] retry_cnt, wait_cnt;
   logic [19:0] delay_cnt;
   logic [7:0]  last_r1;
   logic [1:0]  cap_bits;
   logic        cs_lvl;
   logic [1:0]  fail_code;

   int          out_kind;
   logic [7:0]  out_tx;
   logic        out_cs;
   logic [1:0]  out_status;

   sdi_pkg::rsp_type expected_rsp[$];

   function void emit_byte(logic [7:0] b);
      out_kind = 1;
      out_tx = b;
      out_cs = cs_lvl;
   endfunction

   function void finish_seq(logic [1:0] s);
      ph = sdi_pkg::PH_DONE;
      out_kind = 2;
      out_status = s;
      out_cs = cs_lvl;
   endfunction

   function void go_deselect();
      ph = sdi_pkg::PH_DESEL;
      byte_idx = 3'd0;
      emit_byte(8'hFF);
      cs_lvl = 1'b1;
   endfunction

   function void go_select();
      ph = sdi_pkg::PH_SEL;
      byte_idx = 3'd0;
      emit_byte(8'hFF);
      cs_lvl = 1'b0;
   endfunction

   function logic [7:0] cmd_frame_byte(logic [2:0] i);
      logic [7:0]  cmd;
      logic [31:0] arg;
      logic [7:0]  crc;
      cmd = 8'd58;
      arg = 32'd0;
      crc = 8'hFF;
      case (stg)
         sdi_pkg::ST_CMD0: begin cmd = 8'd0; crc = 8'h95; end
         sdi_pkg::ST_CMD8: begin cmd = 8'd8; arg = if_arg; crc = 8'h87; end
         sdi_pkg::ST_CMD55: cmd = 8'd55;
         sdi_pkg::ST_ACMD41: begin cmd = 8'd41; arg = op_arg; end
         default: cmd = 8'd58;
      endcase
      if (i == 3'd0) return 8'h40 | cmd;
      if (i >= 3'd5) return crc;
      return 8'(arg >> (8 * (4 - int'(i))));
   endfunction

   function void go_frame();
      ph = sdi_pkg::PH_FRAME;
      byte_idx = 3'd0;
      emit_byte(cmd_frame_byte(3'd0));
   endfunction

   function void open_stage(sdi_pkg::stage_type s);
      stg = s;
      retry_cnt = 16'd0;
      go_select();
   endfunction

   function void delay_expired();
      if (stg == sdi_pkg::ST_POWER) begin
         ph = sdi_pkg::PH_IDLECLK;
         poll_cnt = 9'd0;
         emit_byte(8'hFF);
      end else if (stg == sdi_pkg::ST_CMD55 || stg == sdi_pkg::ST_ACMD41) begin
         retry_cnt = retry_cnt + 16'd1;
         if (retry_cnt >= init_limit) begin
            finish_seq(sdi_pkg::STAT_TIMEOUT);
         end else begin
            stg = sdi_pkg::ST_CMD55;
            go_select();
         end
      end else begin
         retry_cnt = retry_cnt + 16'd1;
         if (retry_cnt >= ready_limit) begin
            fail_code = sdi_pkg::STAT_TIMEOUT;
            go_deselect();
         end else begin
            go_frame();
         end
      end
   endfunction

   function void go_delay(logic [19:0] n);
      delay_cnt = n;
      if (delay_cnt == 20'd0) delay_expired();
      else ph = sdi_pkg::PH_DELAY;
   endfunction

   function void deselect_done();
      case (stg)
         sdi_pkg::ST_POWER: go_delay(powerup_us);
         sdi_pkg::ST_CMD0: begin
            if (fail_code != 2'd0) finish_seq(fail_code);
            else open_stage(sdi_pkg::ST_CMD8);
         end
         sdi_pkg::ST_CMD8: begin
            if (fail_code != 2'd0) finish_seq(fail_code);
            else open_stage(sdi_pkg::ST_CMD55);
         end
         sdi_pkg::ST_CMD55: begin
            if (last_r1 < 8'd2) begin
               stg = sdi_pkg::ST_ACMD41;
               go_select();
            end else begin
               go_delay(20'd100);
            end
         end
         sdi_pkg::ST_ACMD41: begin
            if (last_r1 == 8'd0) open_stage(sdi_pkg::ST_CMD58);
            else go_delay(20'd100);
         end
         default: finish_seq(fail_code);
      endcase
   endfunction

   function void go_extra();
      ph = sdi_pkg::PH_EXTRA;
      byte_idx = 3'd0;
      emit_byte(8'hFF);
   endfunction

   function void got_r1(logic [7:0] r);
      last_r1 = r;
      case (stg)
         sdi_pkg::ST_CMD0: if (r == 8'h01) go_deselect(); else go_delay(20'd1);
         sdi_pkg::ST_CMD8: if (r == 8'h01) go_extra(); else go_delay(20'd1);
         sdi_pkg::ST_CMD58: if (r == 8'h00) go_extra(); else go_delay(20'd1);
         default: go_deselect();
      endcase
   endfunction

   function void got_byte(logic [7:0] rx);
      case (ph)
         sdi_pkg::PH_DESEL: begin
            if (byte_idx == 3'd0) begin
               byte_idx = 3'd1;
               emit_byte(8'hFF);
            end else begin
               deselect_done();
            end
         end
         sdi_pkg::PH_IDLECLK: begin
            poll_cnt = poll_cnt + 9'd1;
            if (poll_cnt < 9'd10) emit_byte(8'hFF);
            else open_stage(sdi_pkg::ST_CMD0);
         end
         sdi_pkg::PH_SEL: begin
            if (byte_idx == 3'd0) begin
               byte_idx = 3'd1;
            end else begin
               ph = sdi_pkg::PH_WAIT;
               wait_cnt = 16'd0;
            end
            emit_byte(8'hFF);
         end
         sdi_pkg::PH_WAIT: begin
            if (rx == 8'hFF) begin
               go_frame();
            end else begin
               wait_cnt = wait_cnt + 16'd1;
               if (wait_cnt >= ready_limit) finish_seq(sdi_pkg::STAT_BUSY);
               else emit_byte(8'hFF);
            end
         end
         sdi_pkg::PH_FRAME: begin
            byte_idx = byte_idx + 3'd1;
            if (byte_idx < 3'd6) begin
               emit_byte(cmd_frame_byte(byte_idx));
            end else begin
               ph = sdi_pkg::PH_POLL;
               poll_cnt = 9'd0;
               emit_byte(8'hFF);
            end
         end
         sdi_pkg::PH_POLL: begin
            poll_cnt = poll_cnt + 9'd1;
            if (rx[7] && poll_cnt < 9'd256) emit_byte(8'hFF);
            else got_r1(rx);
         end
         sdi_pkg::PH_EXTRA: begin
            if (byte_idx == 3'd0 && stg == sdi_pkg::ST_CMD58) last_r1 = rx;
            byte_idx = byte_idx + 3'd1;
            if (byte_idx < 3'd4) begin
               emit_byte(8'hFF);
            end else begin
               if (stg == sdi_pkg::ST_CMD8) begin
                  last_r1 = rx;
                  if (rx != if_arg[7:0]) fail_code = sdi_pkg::STAT_MISMATCH;
               end else if (last_r1[7]) begin
                  cap_bits = {last_r1[6], 1'b1};
               end
               go_deselect();
            end
         end
         default: ;
      endcase
   endfunction

   function void clear_model();
      ready_limit = 16'd1000;
      init_limit = 16'd1000;
      powerup_us = 20'd50000;
      if_arg = 32'h1AA;
      op_arg = 32'h4000_0000;
      ph = sdi_pkg::PH_OFF;
      stg = sdi_pkg::ST_POWER;
      byte_idx = 3'd0;
      poll_cnt = 9'd0;
      retry_cnt = 16'd0;
      wait_cnt = 16'd0;
      delay_cnt = 20'd0;
      last_r1 = 8'hFF;
      cap_bits = 2'd0;
      cs_lvl = 1'b1;
      fail_code = 2'd0;
   endfunction

   function void write_register(logic [sdi_pkg::IDX_W-1:0] idx,
                                logic [sdi_pkg::CSR_DATA_W-1:0] v);
      case (idx)
         sdi_pkg::CSR_READY_LIMIT: ready_limit = v[15:0];
         sdi_pkg::CSR_INIT_LIMIT: init_limit = v[15:0];
         sdi_pkg::CSR_POWERUP: powerup_us = v[19:0];
         sdi_pkg::CSR_IF_COND: if_arg = v;
         sdi_pkg::CSR_OP_COND: op_arg = v;
         default: ;
      endcase
   endfunction

   function void predict_request(sdi_pkg::req_type r);
      sdi_pkg::rsp_type e;
      out_kind = 0;
      if (r.kind == sdi_pkg::KIND_START) begin
         cap_bits = 2'd0;
         fail_code = 2'd0;
         retry_cnt = 16'd0;
         poll_cnt = 9'd0;
         wait_cnt = 16'd0;
         delay_cnt = 20'd0;
         last_r1 = 8'hFF;
         stg = sdi_pkg::ST_POWER;
         go_deselect();
      end else if (r.kind == sdi_pkg::KIND_BYTE) begin
         got_byte(r.rx_byte);
      end else if (r.kind == sdi_pkg::KIND_TICK && ph == sdi_pkg::PH_DELAY) begin
         delay_cnt = delay_cnt - 20'd1;
         if (delay_cnt == 20'd0) delay_expired();
      end
      if (out_kind != 0) begin
         e = '0;
         e.cs_high = out_cs;
         if (out_kind == 1) begin
            e.tx_valid = 1'b1;
            e.tx_byte = out_tx;
         end else begin
            e.done_res = 1'b1;
            e.status = out_status;
            e.block_addr = cap_bits[1];
            e.capacity_known = cap_bits[0];
         end
         expected_rsp.push_back(e);
      end
   endfunction

   always @(posedge clock) begin
      sdi_pkg::rsp_type want;
      if (reset) begin
         clear_model();
         expected_rsp.delete();
         errors = 0;
         results_seen = 0;
      end else begin
         if (csr_we) write_register(csr_index, csr_wdata);
         if (rsp.valid && rsp.ready) begin
            results_seen++;
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t unexpected result %p", $time, rsp.data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp.data.tx_valid !== want.tx_valid ||
                   rsp.data.tx_byte !== want.tx_byte ||
                   rsp.data.cs_high !== want.cs_high ||
                   rsp.data.done_res !== want.done_res ||
                   rsp.data.status !== want.status ||
                   rsp.data.block_addr !== want.block_addr ||
                   rsp.data.capacity_known !== want.capacity_known) begin
                  errors++;
                  $display("%0t mismatch expected %p actual %p", $time, want, rsp.data);
               end
            end
         end
         if (req.valid && req.ready) predict_request(req.data);
      end
      pending <= expected_rsp.size();
      hint_phase <= ph;
      hint_stage <= stg;
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: bring-up sequencer testbench
// Plays a loosely behaved card against the sequencer: starts, ticks and
// received bytes steered toward the running stage, mixed with noise, over
// many register settings and three idling patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;

   logic clock;
   logic reset;
   logic csr_we;
   logic [sdi_pkg::IDX_W-1:0] csr_index;
   logic [sdi_pkg::CSR_DATA_W-1:0] csr_wdata;

   sdi_req_if req_ch();
   sdi_rsp_if rsp_ch();

   int errors, pending, results_seen;
   sdi_pkg::phase_type hint_phase;
   sdi_pkg::stage_type hint_stage;

   int tx_idle, rx_idle;
   bit hold_req;
   int hold_cnt;
   int requests_sent, runs;
   int quiet_cycles;
   logic [7:0] if_low;

   sd_spi_init_sequencer uut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   tb_checker chk (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending), .results_seen(results_seen),
      .hint_phase(hint_phase), .hint_stage(hint_stage)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // receiver side, with long hold-off on request
   initial begin
      hold_cnt = 0;
      rsp_ch.ready = 0;
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_cnt = 400;
            hold_req = 0;
         end
         if (hold_cnt > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cnt--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
         end
      end
   end

   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= 3000) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_request(logic [1:0] kind, logic [7:0] rx);
      while ($urandom_range(0, 99) < tx_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= '{kind: kind, rx_byte: rx};
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      requests_sent++;
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [sdi_pkg::IDX_W-1:0] idx,
                            logic [sdi_pkg::CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_limit();
      int sel;
      sel = $urandom_range(0, 11);
      if (sel == 0) return 32'd0;
      if (sel == 1) return 32'd65535;
      return 32'($urandom_range(1, 6));
   endfunction

   task automatic write_settings();
      logic [31:0] rdy, ini, pwr, ifc, opc;
      int sel;
      rdy = pick_limit();
      ini = pick_limit();
      sel = $urandom_range(0, 24);
      if (sel == 0) pwr = 32'h000F_FFFF;
      else if (sel < 4) pwr = 32'd0;
      else pwr = 32'($urandom_range(1, 4));
      sel = $urandom_range(0, 9);
      ifc = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : 32'($urandom);
      sel = $urandom_range(0, 9);
      opc = (sel == 0) ? 32'h0 : (sel == 1) ? 32'hFFFF_FFFF : 32'($urandom);
      if_low = ifc[7:0];
      write_reg(sdi_pkg::CSR_READY_LIMIT, rdy);
      write_reg(sdi_pkg::CSR_INIT_LIMIT, ini);
      write_reg(sdi_pkg::CSR_POWERUP, pwr);
      write_reg(sdi_pkg::CSR_IF_COND, ifc);
      write_reg(sdi_pkg::CSR_OP_COND, opc);
      csr_we <= 1'b0;
   endtask

   task automatic card_request();
      logic [1:0] kind;
      logic [7:0] rx;
      int r;
      r = $urandom_range(0, 99);
      kind = sdi_pkg::KIND_BYTE;
      rx = 8'hFF;
      if (r < 2) begin
         kind = sdi_pkg::KIND_START;
         rx = 8'($urandom);
      end else if (r < 10) begin
         kind = 2'($urandom);
         rx = 8'($urandom);
      end else if (hint_phase == sdi_pkg::PH_DELAY) begin
         kind = ($urandom_range(0, 9) == 0) ? sdi_pkg::KIND_BYTE : sdi_pkg::KIND_TICK;
      end else if (hint_phase == sdi_pkg::PH_WAIT) begin
         if ($urandom_range(0, 4) == 0) rx = 8'($urandom);
      end else if (hint_phase == sdi_pkg::PH_POLL) begin
         r = $urandom_range(0, 9);
         case (hint_stage)
            sdi_pkg::ST_CMD0, sdi_pkg::ST_CMD8: rx = (r < 7) ? 8'h01 : 8'($urandom);
            sdi_pkg::ST_CMD55:
               rx = (r < 4) ? 8'h01 : (r < 8) ? 8'h00 : 8'($urandom);
            sdi_pkg::ST_ACMD41:
               rx = (r < 6) ? 8'h00 : (r < 8) ? 8'h01 : 8'($urandom);
            default: rx = (r < 5) ? 8'h00 : (8'h80 | 8'($urandom));
         endcase
      end else if (hint_phase == sdi_pkg::PH_EXTRA) begin
         rx = ($urandom_range(0, 9) < 6) ? if_low : 8'($urandom);
      end
      send_request(kind, rx);
   endtask

   task automatic card_run(int left);
      int budget;
      wait_drained();
      write_settings();
      runs++;
      send_request(sdi_pkg::KIND_START, 8'($urandom));
      budget = $urandom_range(40, 220);
      if (budget > left) budget = left;
      for (int n = 0; n < budget; n++) begin
         card_request();
         if (hint_phase == sdi_pkg::PH_DONE) begin
            send_request(2'($urandom), 8'($urandom));
            break;
         end
      end
   endtask

   initial begin
      int target;
      reset = 1;
      req_ch.valid = 0;
      req_ch.data = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      tx_idle = 21;
      rx_idle = 73;
      hold_req = 0;
      requests_sent = 0;
      runs = 0;
      if_low = 8'hAA;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // ignored inputs before any start, then a start under reset settings
      send_request(sdi_pkg::KIND_SPARE, 8'h00);
      send_request(sdi_pkg::KIND_BYTE, 8'h00);
      send_request(sdi_pkg::KIND_TICK, 8'hFF);
      send_request(sdi_pkg::KIND_BYTE, 8'hFF);
      send_request(sdi_pkg::KIND_START, 8'h00);
      send_request(sdi_pkg::KIND_TICK, 8'h00);
      send_request(sdi_pkg::KIND_TICK, 8'h00);
      send_request(sdi_pkg::KIND_BYTE, 8'h5A);
      send_request(sdi_pkg::KIND_START, 8'hFF);
      send_request(sdi_pkg::KIND_BYTE, 8'hFF);
      send_request(sdi_pkg::KIND_BYTE, 8'hFF);
      send_request(sdi_pkg::KIND_SPARE, 8'hA5);

      for (int mode = 0; mode < 3; mode++) begin
         tx_idle = (mode == 0) ? 21 : (mode == 1) ? 73 : 0;
         rx_idle = (mode == 0) ? 73 : (mode == 1) ? 21 : 0;
         target = requests_sent + 546;
         if (mode == 2) begin
            wait_drained();
            hold_req = 1;
         end
         while (requests_sent < target) card_run(target - requests_sent - 1);
      end

      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d requests and %0d results over %0d start-up runs",
               requests_sent, results_seen, runs);
      $display("settings varied per run, idling patterns on both channels");
      if (errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
